/* design/length_prefixed_frame_deframer_unit_assert.svh */
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define LPFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define LPFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lpfd_pkg.sv */
package lpfd_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] len_t;
	typedef logic [1:0]  kind_t;

	localparam byte_t HDR_FIRST  = 8'hAA;
	localparam byte_t HDR_SECOND = 8'h55;
	localparam byte_t TRL_FIRST  = 8'h55;
	localparam byte_t TRL_SECOND = 8'hAA;

	localparam kind_t KIND_DATA = 2'd0;
	localparam kind_t KIND_GOOD = 2'd1;
	localparam kind_t KIND_BAD  = 2'd2;

endpackage

/* design/length_prefixed_frame_deframer_unit.sv */
// length-prefixed frame deframer
// input channel (in_valid/in_ready, rx_byte): one received byte per item
// frame layout: 0xAA 0x55, length low, length high, payload, 0x55 0xAA
// output channel (out_valid/out_ready, kind, data_byte, frame_length):
//   kind 0 is a payload byte passed cut-through, data_byte holds it
//   kind 1/2 is the end of a frame with good/bad trailer, frame_length holds
//   the payload length; header, length and first trailer bytes give no item
// a bad second header byte restarts the header hunt (0xAA counts as a new
// first header byte); a bad trailer still consumes both trailer bytes
// an accepted byte lands in the input register, and its result is then
// presented from the output register
// throughput: one byte per cycle unless a result waits on the output register,
// set by the single frame state machine that takes its byte from the input register
// stall: when out_ready is low the output register holds its item; bytes that
// give no result keep flowing, and a byte that gives a result waits in the
// input register, blocking the input, until the output register frees
// reset (arst_n low): hunting for a header, both registers empty
module length_prefixed_frame_deframer_unit
	import lpfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] frame_length
);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_HDR2  = 3'd1;
	localparam logic [2:0] PH_LENLO = 3'd2;
	localparam logic [2:0] PH_LENHI = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_TRL1  = 3'd5;
	localparam logic [2:0] PH_TRL2  = 3'd6;

	logic       valid_s1;
	byte_t      byte_s1;
	logic [2:0] phase_q;
	len_t       length_q;
	len_t       seen_q;
	logic       trl_ok_q;
	logic       out_valid_q;
	kind_t      kind_q;
	byte_t      data_q;
	len_t       flen_q;

	logic       emit;
	logic       out_free;
	logic       advance;
	logic [2:0] phase_d;
	len_t       length_d;
	len_t       seen_d;
	len_t       seen_inc;
	logic       trl_ok_d;
	kind_t      kind_d;
	byte_t      data_d;
	len_t       flen_d;

	assign emit     = (phase_q == PH_DATA) || (phase_q == PH_TRL2);
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || advance;
	assign seen_inc = seen_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		seen_d   = seen_q;
		trl_ok_d = trl_ok_q;
		kind_d   = KIND_DATA;
		data_d   = '0;
		flen_d   = '0;
		unique case (phase_q)
			PH_HDR2: begin
				if (byte_s1 == HDR_SECOND) begin
					phase_d = PH_LENLO;
				end else if (byte_s1 == HDR_FIRST) begin
					phase_d = PH_HDR2;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LENLO: begin
				length_d = {8'd0, byte_s1};
				phase_d  = PH_LENHI;
			end
			PH_LENHI: begin
				length_d = {byte_s1, length_q[7:0]};
				seen_d   = '0;
				phase_d  = ({byte_s1, length_q[7:0]} == 16'd0) ? PH_TRL1 : PH_DATA;
			end
			PH_DATA: begin
				data_d = byte_s1;
				seen_d = seen_inc;
				if (seen_inc == length_q) begin
					phase_d = PH_TRL1;
				end
			end
			PH_TRL1: begin
				trl_ok_d = (byte_s1 == TRL_FIRST);
				phase_d  = PH_TRL2;
			end
			PH_TRL2: begin
				kind_d  = (trl_ok_q && byte_s1 == TRL_SECOND) ? KIND_GOOD : KIND_BAD;
				flen_d  = length_q;
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = (byte_s1 == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			length_q <= '0;
			seen_q   <= '0;
			trl_ok_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			seen_q   <= seen_d;
			trl_ok_q <= trl_ok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q <= kind_d;
			data_q <= data_d;
			flen_q <= flen_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign frame_length = flen_q;

`include "length_prefixed_frame_deframer_unit_assert.svh"

	`LPFD_ASSERT_NOW(a_kind_code, out_valid_q,
		kind_q == KIND_DATA || kind_q == KIND_GOOD || kind_q == KIND_BAD,
		"output kind code out of range")
	`LPFD_ASSERT_NOW(a_end_no_data, out_valid_q && kind_q != KIND_DATA,
		data_q == 8'd0, "end item carries a data byte")
	`LPFD_ASSERT_NOW(a_seen_bound, phase_q == PH_DATA,
		seen_q < length_q, "payload count reached length inside payload")
	`LPFD_ASSERT_NEXT(a_trailer_end, advance && phase_q == PH_TRL2,
		out_valid_q && kind_q != KIND_DATA && phase_q == PH_HUNT,
		"trailer byte did not produce an end item")

endmodule
